[rtl/core/hwg_pkg.sv]
package hwg_pkg;

   // Fixed field widths of the block.
   localparam int COORD_W = 10;
   localparam int CSR_W = 9;
   localparam int FRAC_BITS = 16;
   localparam int WEIGHT_W = FRAC_BITS + 1;
   localparam int REGION_W = 2;

   // Map geometry and configuration defaults.
   localparam int MAP_QUARTERS = 4;
   localparam int MAX_QUARTER_DEF = 256;
   localparam logic [CSR_W-1:0] QUARTER_RESET = CSR_W'(64);

   // Face that a pixel falls on.
   typedef enum logic [REGION_W-1:0] {
      REGION_NONE   = 2'd0,
      REGION_CENTER = 2'd1,
      REGION_SIDE   = 2'd2,
      REGION_CAP    = 2'd3
   } region_type;

endpackage

[rtl/core/hwg_divider.sv]
// Pipelined restoring divider: one quotient bit per stage, most significant first.
// The dividend never exceeds the divisor, so the quotient fits in WEIGHT_W bits.
module hwg_divider
   import hwg_pkg::*;
#(
   parameter int NW = 18,
   parameter int DW = 20
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  logic [NW-1:0]       in_num,
   input  logic [DW-1:0]       in_den,
   input  region_type          in_region,
   output logic                out_valid,
   input  logic                out_ready,
   output logic [WEIGHT_W-1:0] out_weight,
   output region_type          out_region
);

   localparam int QB = WEIGHT_W;

   logic                valid_ff  [QB];
   logic                open      [QB];
   logic [DW-1:0]       rem_ff    [QB];
   logic [DW-1:0]       den_ff    [QB];
   logic [WEIGHT_W-1:0] quo_ff    [QB];
   region_type          region_ff [QB];

   for (genvar j = 0; j < QB; j++) begin : g_stage
      logic                src_valid;
      logic [DW-1:0]       src_rem;
      logic [DW-1:0]       src_den;
      logic [WEIGHT_W-1:0] src_quo;
      region_type          src_region;
      logic [DW:0]         trial;
      logic                fits;
      logic [DW-1:0]       rem_in;
      logic [WEIGHT_W-1:0] quo_in;

      // A stage takes new data when it is empty or its content moves on.
      if (j == QB - 1) begin : g_last
         assign open[j] = !valid_ff[j] || out_ready;
      end else begin : g_mid
         assign open[j] = !valid_ff[j] || open[j+1];
      end

      // The first stage compares the dividend itself, later stages the doubled remainder.
      if (j == 0) begin : g_first
         assign src_valid  = in_valid;
         assign src_rem    = DW'(in_num);
         assign src_den    = in_den;
         assign src_quo    = '0;
         assign src_region = in_region;
         assign trial      = {1'b0, src_rem};
      end else begin : g_next
         assign src_valid  = valid_ff[j-1];
         assign src_rem    = rem_ff[j-1];
         assign src_den    = den_ff[j-1];
         assign src_quo    = quo_ff[j-1];
         assign src_region = region_ff[j-1];
         assign trial      = {src_rem, 1'b0};
      end

      // Trial subtraction decides one quotient bit.
      always_comb begin
         fits   = trial >= {1'b0, src_den};
         rem_in = fits ? DW'(trial - {1'b0, src_den}) : DW'(trial);
         quo_in = {src_quo[WEIGHT_W-2:0], fits};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[j] <= 1'b0;
         end else if (open[j]) begin
            valid_ff[j] <= src_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (open[j]) begin
            rem_ff[j]    <= rem_in;
            den_ff[j]    <= src_den;
            quo_ff[j]    <= quo_in;
            region_ff[j] <= src_region;
         end
      end
   end

   assign in_ready   = open[0];
   assign out_valid  = valid_ff[QB-1];
   assign out_region = region_ff[QB-1];
   // Pixels off every face carry no weight.
   assign out_weight = (region_ff[QB-1] == REGION_NONE) ? '0 : quo_ff[QB-1];

endmodule

[rtl/core/hemicube_weight_generator.sv]
// Hemicube delta form factor weight generator.
//
// Each request carries a pixel coordinate of the unfolded hemicube map; each
// response returns that pixel's weight in unsigned Q1.16 and the face it lies on.
// The quarter edge is set through the csr port, takes effect for requests
// accepted after the write, and saturates at MAX_QUARTER.
//
// Both channels use valid/ready. The block is a twenty-stage pipeline: three
// stages classify the pixel, form the squares and sum the denominator, and a
// seventeen-stage restoring divider produces one quotient bit per stage.
// One request is accepted every cycle as long as responses are taken.
//
// When the receiver stalls, each stage still fills its empty slot, so requests
// keep being accepted until the pipeline holds twenty items; the last stage then
// holds its response unchanged. Reset clears all valid bits and sets the quarter
// edge to 64; the pipeline is empty and ready in the first cycle after reset.
module hemicube_weight_generator
   import hwg_pkg::*;
#(
   parameter int MAX_QUARTER = MAX_QUARTER_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_write_enable,
   input  logic [CSR_W-1:0]    csr_write_data,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [COORD_W-1:0]  req_pixel_x,
   input  logic [COORD_W-1:0]  req_pixel_y,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [WEIGHT_W-1:0] rsp_weight,
   output logic [REGION_W-1:0] rsp_region
);

   localparam int QW = $clog2(MAX_QUARTER + 1);
   localparam int CW = ((QW + 2 > COORD_W) ? QW + 2 : COORD_W) + 1;
   localparam int SQW = 2 * QW;
   localparam int DW = SQW + 2;

   // Quarter edge register.
   logic [CSR_W-1:0] csr_quarter_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_quarter_ff <= QUARTER_RESET;
      end else if (csr_write_enable) begin
         csr_quarter_ff <= csr_write_data;
      end
   end

   // Saturated quarter edge.
   logic [QW-1:0] quarter;
   assign quarter = (32'(csr_quarter_ff) > MAX_QUARTER) ? QW'(MAX_QUARTER)
                                                        : QW'(csr_quarter_ff);

   // Handshake chain of the front stages.
   logic cls_valid_ff, mul_valid_ff, sum_valid_ff;
   logic cls_open, mul_open, sum_open;
   logic div_in_ready;

   assign sum_open  = !sum_valid_ff || div_in_ready;
   assign mul_open  = !mul_valid_ff || sum_open;
   assign cls_open  = !cls_valid_ff || mul_open;
   assign req_ready = cls_open;

   always_ff @(posedge clock) begin
      if (reset) begin
         cls_valid_ff <= 1'b0;
         mul_valid_ff <= 1'b0;
         sum_valid_ff <= 1'b0;
      end else begin
         if (cls_open) begin
            cls_valid_ff <= req_valid;
         end
         if (mul_open) begin
            mul_valid_ff <= cls_valid_ff;
         end
         if (sum_open) begin
            sum_valid_ff <= mul_valid_ff;
         end
      end
   end

   // Classification: face, the two distance terms and the numerator factor.
   logic [CW-1:0] px, py, qx, side, two_q, three_q;
   logic          in_map, xmid, ymid;
   logic [CW-1:0] adx, ady, dxs, dys;
   region_type    region_in;
   logic [QW-1:0] term_a_in, term_b_in, factor_in;

   always_comb begin
      px      = CW'(req_pixel_x);
      py      = CW'(req_pixel_y);
      qx      = CW'(quarter);
      side    = qx << 2;
      two_q   = qx << 1;
      three_q = side - qx;
      in_map  = (quarter != '0) && (px < side) && (py < side);
      xmid    = (px >= qx) && (px < three_q);
      ymid    = (py >= qx) && (py < three_q);
      adx     = (px >= two_q) ? px - two_q : two_q - px;
      ady     = (py >= two_q) ? py - two_q : two_q - py;
      dxs     = (px < qx) ? px : side - CW'(1) - px;
      dys     = (py < qx) ? py : side - CW'(1) - py;

      region_in = REGION_NONE;
      term_a_in = '0;
      term_b_in = '0;
      factor_in = '0;
      if (in_map && xmid && ymid) begin
         region_in = REGION_CENTER;
         term_a_in = QW'(adx);
         term_b_in = QW'(ady);
         factor_in = quarter;
      end else if (in_map && ymid) begin
         region_in = REGION_SIDE;
         term_a_in = QW'(dxs);
         term_b_in = QW'(ady);
         factor_in = QW'(dxs);
      end else if (in_map && xmid) begin
         region_in = REGION_CAP;
         term_a_in = QW'(adx);
         term_b_in = QW'(dys);
         factor_in = QW'(dys);
      end
   end

   region_type    cls_region_ff;
   logic [QW-1:0] cls_quarter_ff, cls_term_a_ff, cls_term_b_ff, cls_factor_ff;

   always_ff @(posedge clock) begin
      if (cls_open) begin
         cls_region_ff  <= region_in;
         cls_quarter_ff <= quarter;
         cls_term_a_ff  <= term_a_in;
         cls_term_b_ff  <= term_b_in;
         cls_factor_ff  <= factor_in;
      end
   end

   // Squares and numerator, four small multipliers side by side.
   region_type     mul_region_ff;
   logic [SQW-1:0] mul_qq_ff, mul_sqa_ff, mul_sqb_ff, mul_num_ff;

   always_ff @(posedge clock) begin
      if (mul_open) begin
         mul_region_ff <= cls_region_ff;
         mul_qq_ff     <= SQW'(cls_quarter_ff) * SQW'(cls_quarter_ff);
         mul_sqa_ff    <= SQW'(cls_term_a_ff) * SQW'(cls_term_a_ff);
         mul_sqb_ff    <= SQW'(cls_term_b_ff) * SQW'(cls_term_b_ff);
         mul_num_ff    <= SQW'(cls_quarter_ff) * SQW'(cls_factor_ff);
      end
   end

   // Denominator sum.
   region_type     sum_region_ff;
   logic [SQW-1:0] sum_num_ff;
   logic [DW-1:0]  sum_den_ff;

   always_ff @(posedge clock) begin
      if (sum_open) begin
         sum_region_ff <= mul_region_ff;
         sum_num_ff    <= mul_num_ff;
         sum_den_ff    <= DW'(mul_qq_ff) + DW'(mul_sqa_ff) + DW'(mul_sqb_ff);
      end
   end

   // Quotient pipeline.
   region_type div_out_region;

   hwg_divider #(
      .NW (SQW),
      .DW (DW)
   ) u_divider (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (sum_valid_ff),
      .in_ready   (div_in_ready),
      .in_num     (sum_num_ff),
      .in_den     (sum_den_ff),
      .in_region  (sum_region_ff),
      .out_valid  (rsp_valid),
      .out_ready  (rsp_ready),
      .out_weight (rsp_weight),
      .out_region (div_out_region)
   );

   assign rsp_region = REGION_W'(div_out_region);

endmodule

[rtl/core/hwg_monitor.sv]
// Port-level checks of the weight generator.
module hwg_monitor
   import hwg_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [WEIGHT_W-1:0] rsp_weight,
   input logic [REGION_W-1:0] rsp_region
);

   localparam logic [WEIGHT_W-1:0] ONE = WEIGHT_W'(1) << FRAC_BITS;
   localparam logic [WEIGHT_W-1:0] THIRD = WEIGHT_W'((1 << FRAC_BITS) / 3);

   // A stalled response holds its content.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_weight) && $stable(rsp_region))
      else $error("stalled response changed");

   // The pipeline is empty after reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // Off-face pixels weigh nothing and no weight exceeds one.
   a_weight_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_weight <= ONE) &&
                    ((rsp_region != REGION_NONE) || (rsp_weight == '0)))
      else $error("weight out of range for its region");

   // A center pixel is never farther than the corner of the face, so its weight is at least a third.
   a_center_floor: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_region == REGION_CENTER) |-> rsp_weight >= THIRD)
      else $error("center weight below one third");

   // With the output stage empty every stage can take new data, so a request is always taken.
   a_drain_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready || !req_valid)
      else $error("request stalled with an empty output");

endmodule

bind hemicube_weight_generator hwg_monitor u_monitor (.*);

[tb/hwg_weight_checker.sv]
module hwg_weight_checker
   import hwg_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_write_enable,
   input  logic [CSR_W-1:0]    csr_write_data,
   input  logic                req_valid,
   input  logic                req_ready,
   input  logic [COORD_W-1:0]  req_pixel_x,
   input  logic [COORD_W-1:0]  req_pixel_y,
   input  logic                rsp_valid,
   input  logic                rsp_ready,
   input  logic [WEIGHT_W-1:0] rsp_weight,
   input  logic [REGION_W-1:0] rsp_region,
   output int                  outstanding,
   output int                  fail_count,
   output int                  checked_count
);

   // One predicted response, with the pixel kept for the mismatch report.
   typedef struct {
      logic [COORD_W-1:0]  px;
      logic [COORD_W-1:0]  py;
      logic [WEIGHT_W-1:0] weight;
      region_type          region;
   } pixel_weight_type;

   pixel_weight_type    weights_due[$];
   logic [CSR_W-1:0]    quarter = QUARTER_RESET;

   // Delta form factor of one map pixel for a given quarter edge.
   function automatic pixel_weight_type face_weight(input logic [CSR_W-1:0] qreg,
                                                    input logic [COORD_W-1:0] px,
                                                    input logic [COORD_W-1:0] py);
      longint           q;
      longint           side;
      longint           x;
      longint           y;
      longint           dx;
      longint           dy;
      longint           d;
      longint           num;
      longint           den;
      longint           w;
      bit               xmid;
      bit               ymid;
      pixel_weight_type r;
      r.px = px;
      r.py = py;
      r.weight = '0;
      r.region = REGION_NONE;
      q = qreg;
      if (q > MAX_QUARTER_DEF) begin
         q = MAX_QUARTER_DEF;
      end
      side = MAP_QUARTERS * q;
      x = px;
      y = py;
      num = 0;
      den = 0;
      if (q > 0 && x < side && y < side) begin
         xmid = (x >= q) && (x < 3 * q);
         ymid = (y >= q) && (y < 3 * q);
         dx = x - 2 * q;
         dy = y - 2 * q;
         if (xmid && ymid) begin
            r.region = REGION_CENTER;
            num = q * q;
            den = q * q + dx * dx + dy * dy;
         end else if (ymid) begin
            // Left or right face: distance from the outer edge.
            d = (x < q) ? x : side - 1 - x;
            r.region = REGION_SIDE;
            num = q * d;
            den = q * q + d * d + dy * dy;
         end else if (xmid) begin
            // Top or bottom face: same rule with the axes swapped.
            d = (y < q) ? y : side - 1 - y;
            r.region = REGION_CAP;
            num = q * d;
            den = q * q + dx * dx + d * d;
         end
      end
      if (den != 0) begin
         w = (num * 65536) / den;
         if (w > 65536) begin
            w = 65536;
         end
         r.weight = WEIGHT_W'(w);
      end
      return r;
   endfunction

   // Watch both channels and the register port on every rising edge.
   always @(posedge clock) begin : watch
      pixel_weight_type due;
      int               delta;
      delta = 0;
      if (reset) begin
         weights_due.delete();
         quarter <= QUARTER_RESET;
         outstanding <= 0;
      end else begin
         // Responses are compared before this edge's request is queued.
         if (rsp_valid && rsp_ready) begin
            if (weights_due.size() == 0) begin
               fail_count++;
               if (fail_count <= 10) begin
                  $display("unexpected response: weight %0d region %0d with no request open",
                           rsp_weight, rsp_region);
               end
            end else begin
               due = weights_due.pop_front();
               delta = delta - 1;
               checked_count++;
               if (rsp_weight !== due.weight || rsp_region !== due.region) begin
                  fail_count++;
                  if (fail_count <= 10) begin
                     $display("pixel (%0d,%0d): expected weight %0d region %0d, got %0d %0d",
                              due.px, due.py, due.weight, due.region,
                              rsp_weight, rsp_region);
                  end
               end
            end
         end
         if (req_valid && req_ready) begin
            weights_due.push_back(face_weight(quarter, req_pixel_x, req_pixel_y));
            delta = delta + 1;
         end
         outstanding <= outstanding + delta;
         // A new quarter edge applies to requests after this edge.
         if (csr_write_enable) begin
            quarter <= csr_write_data;
         end
      end
   end

endmodule

[tb/hemicube_weight_generator_tb.sv]
module hemicube_weight_generator_tb
   import hwg_pkg::*;
();

   localparam int CYCLE_LIMIT = 200000;

   logic                clock = 1'b0;
   logic                reset;
   logic                csr_write_enable;
   logic [CSR_W-1:0]    csr_write_data;
   logic                req_valid;
   logic                req_ready;
   logic [COORD_W-1:0]  req_pixel_x;
   logic [COORD_W-1:0]  req_pixel_y;
   logic                rsp_valid;
   logic                rsp_ready;
   logic [WEIGHT_W-1:0] rsp_weight;
   logic [REGION_W-1:0] rsp_region;

   int                  outstanding;
   int                  fail_count;
   int                  checked_count;
   int                  cycle_count = 0;
   int                  ready_hold = 0;
   int                  pixels_sent = 0;
   int                  settings_used = 1;
   int                  quarter_now = 64;
   bit                  calm = 1'b0;

   hemicube_weight_generator dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_pixel_x      (req_pixel_x),
      .req_pixel_y      (req_pixel_y),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_weight       (rsp_weight),
      .rsp_region       (rsp_region)
   );

   hwg_weight_checker weight_check (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_pixel_x      (req_pixel_x),
      .req_pixel_y      (req_pixel_y),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_weight       (rsp_weight),
      .rsp_region       (rsp_region),
      .outstanding      (outstanding),
      .fail_count       (fail_count),
      .checked_count    (checked_count)
   );

   // Free-running clock with a period of 10.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Give up if the run hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles with %0d weights still open",
                  cycle_count, outstanding);
         $display("hemicube_weight_generator: mismatch");
         $finish;
      end
   end

   // Response side stalls in random bursts.
   always @(posedge clock) begin
      if (ready_hold > 0) begin
         ready_hold <= ready_hold - 1;
         rsp_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
         ready_hold <= $urandom_range(0, 12);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Present one pixel request, sometimes after an idle burst, and hold it until taken.
   task automatic send_pixel(input int x, input int y);
      if (!calm && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_pixel_x <= COORD_W'(x);
      req_pixel_y <= COORD_W'(y);
      do @(posedge clock); while (!req_ready);
      pixels_sent++;
   endtask

   // Stop sending and wait until every open weight has come back.
   task automatic wait_for_weights();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Write a new quarter edge once the pipeline is empty.
   task automatic change_quarter(input int value);
      wait_for_weights();
      csr_write_enable <= 1'b1;
      csr_write_data <= CSR_W'(value);
      @(posedge clock);
      csr_write_enable <= 1'b0;
      quarter_now = value;
      settings_used++;
   endtask

   // Random pixels, mostly inside the current map, some anywhere in the coordinate range.
   task automatic send_random_pixels(input int count);
      int qe;
      int x;
      int y;
      qe = (quarter_now > MAX_QUARTER_DEF) ? MAX_QUARTER_DEF : quarter_now;
      for (int i = 0; i < count; i++) begin
         if (qe == 0 || $urandom_range(0, 6) == 0) begin
            x = $urandom_range(0, 1023);
            y = $urandom_range(0, 1023);
         end else begin
            x = $urandom_range(0, MAP_QUARTERS * qe - 1);
            y = $urandom_range(0, MAP_QUARTERS * qe - 1);
         end
         send_pixel(x, y);
      end
   endtask

   initial begin
      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_write_data = '0;
      req_valid = 1'b0;
      req_pixel_x = '0;
      req_pixel_y = '0;
      rsp_ready = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed pixels at the reset quarter edge of 64: corners, face edges, outside.
      send_pixel(0, 0);
      send_pixel(255, 255);
      send_pixel(0, 255);
      send_pixel(255, 0);
      send_pixel(128, 128);
      send_pixel(64, 64);
      send_pixel(191, 191);
      send_pixel(0, 128);
      send_pixel(63, 128);
      send_pixel(255, 128);
      send_pixel(192, 100);
      send_pixel(128, 0);
      send_pixel(100, 63);
      send_pixel(128, 255);
      send_pixel(150, 192);
      send_pixel(256, 10);
      send_pixel(10, 256);
      send_pixel(1023, 1023);
      send_pixel(1023, 0);
      send_pixel(0, 1023);
      send_pixel(682, 341);
      send_pixel(341, 682);

      // Random phases across quarter edges, including empty and saturated maps.
      send_random_pixels(50);
      change_quarter(1);
      send_random_pixels(40);
      change_quarter(256);
      send_random_pixels(60);
      change_quarter(511);
      send_random_pixels(30);
      change_quarter(0);
      send_random_pixels(20);
      change_quarter(257);
      send_random_pixels(20);
      change_quarter(5);
      send_random_pixels(40);
      change_quarter(100);
      send_random_pixels(50);
      change_quarter(255);
      send_random_pixels(40);

      // Last stretch at full rate on both sides.
      calm = 1'b1;
      change_quarter($urandom_range(2, 255));
      send_random_pixels(80);

      wait_for_weights();
      repeat (30) @(posedge clock);

      $display("Covered %0d pixel requests over %0d quarter edges, empty and saturated included.",
               pixels_sent, settings_used);
      $display("Compared %0d weights and regions, %0d failures.", checked_count, fail_count);
      if (fail_count == 0) begin
         $display("hemicube_weight_generator: match");
      end else begin
         $display("hemicube_weight_generator: mismatch");
      end
      $finish;
   end

endmodule
